// File: rtl/mlp2r_pkg.sv
package mlp2r_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 9;
  localparam int OPA_W  = 33;
  localparam int PROD_W = 65;
  localparam int RND_W  = 49;
  // bias plus up to 64 rounded products of 49 bits
  localparam int ACC_W  = 58;

  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_PREDICT = 1'b1;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_MEAN,
    CFG_INPUT_INV_SCALE,
    CFG_OUTPUT_SCALE,
    CFG_OUTPUT_MEAN
  } cfg_reg_t;

  typedef struct packed {
    logic                     func;
    logic [IDX_W-1:0]         weight_index;
    logic signed [DATA_W-1:0] weight_value;
    logic signed [DATA_W-1:0] input_sample;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] prediction;
    logic                     saturated;
  } rsp_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RUN,
    SEQ_DRAIN
  } seq_state_t;

  typedef enum logic [2:0] {
    PH_NORM,
    PH_L1,
    PH_L2,
    PH_OUT,
    PH_DEN
  } phase_t;

  typedef enum logic [1:0] {
    SRC_NORM,
    SRC_L1,
    SRC_ACT,
    SRC_DEN
  } src_t;

  typedef enum logic [1:0] {
    DST_X,
    DST_ACT,
    DST_Y,
    DST_RES
  } dst_t;

  typedef struct packed {
    logic vld;
    logic bias;
    logic last;
    src_t src;
    dst_t dst;
  } mac_op_t;

endpackage

// File: rtl/mlp2r_ram.sv
module mlp2r_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/mlp2r_mac.sv
module mlp2r_mac
  import mlp2r_pkg::*;
#(
  parameter int H1 = 16,
  parameter int H2 = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  mac_op_t                         op,
  input  logic signed [DATA_W-1:0]        wdata,
  input  logic signed [DATA_W-1:0]        adata,
  input  logic signed [DATA_W-1:0]        sample,
  input  logic signed [DATA_W-1:0]        in_mean,
  input  logic signed [DATA_W-1:0]        inv_scale,
  input  logic signed [DATA_W-1:0]        out_scale,
  input  logic signed [DATA_W-1:0]        out_mean,
  output logic                            busy,
  output logic                            act_we,
  output logic [$clog2(H1+H2)-1:0]        act_waddr,
  output logic signed [DATA_W-1:0]        act_wdata,
  output logic                            res_vld,
  output rsp_t                            res
);

  localparam int AA = $clog2(H1 + H2);

  mac_op_t                  op1, op2, op3;
  logic signed [OPA_W-1:0]  opa;
  logic signed [DATA_W-1:0] opb;
  logic signed [DATA_W-1:0] biasv;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [RND_W-1:0]  rnd;
  logic signed [DATA_W-1:0] bias2;
  logic signed [ACC_W-1:0]  acc;
  logic signed [DATA_W-1:0] x, y;
  logic                     flag;
  logic [AA-1:0]            ptr;
  logic                     fin, clip;
  logic signed [DATA_W-1:0] sat;
  logic [ACC_W-DATA_W:0]    acc_hi;

  // stage 1: operand select, ram data lines up with op1
  always_comb begin
    opa   = OPA_W'(wdata);
    opb   = adata;
    biasv = wdata;
    case (op1.src)
      SRC_NORM: begin
        opa   = OPA_W'(sample) - OPA_W'(in_mean);
        opb   = inv_scale;
        biasv = '0;
      end
      SRC_L1: begin
        opb = x;
      end
      SRC_DEN: begin
        opa   = OPA_W'(y);
        opb   = out_scale;
        biasv = out_mean;
      end
      default: begin
      end
    endcase
  end

  // stage 2: round half up with floor shift, accumulate
  assign prod_r = prod + PROD_W'(32768);
  assign rnd    = prod_r[PROD_W-1:16];

  // stage 3: clip to 32 bits
  assign acc_hi = acc[ACC_W-1:DATA_W-1];
  assign clip   = !((&acc_hi) || !(|acc_hi));
  assign sat    = clip ? (acc[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                       : {1'b0, {(DATA_W-1){1'b1}}})
                       : acc[DATA_W-1:0];
  assign fin    = op3.vld && op3.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      op1  <= '0;
      op2  <= '0;
      op3  <= '0;
      flag <= 1'b0;
      ptr  <= '0;
    end else begin
      op1 <= op;
      op2 <= op1;
      op3 <= op2;
      if (start) begin
        flag <= 1'b0;
        ptr  <= '0;
      end else begin
        if (fin && clip) begin
          flag <= 1'b1;
        end
        if (act_we) begin
          ptr <= ptr + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod  <= opa * opb;
    bias2 <= biasv;
    if (op2.vld) begin
      if (op2.bias) begin
        acc <= ACC_W'(bias2);
      end else begin
        acc <= acc + ACC_W'(rnd);
      end
    end
    if (fin && op3.dst == DST_X) begin
      x <= sat;
    end
    if (fin && op3.dst == DST_Y) begin
      y <= sat;
    end
  end

  assign busy           = op1.vld || op2.vld || op3.vld;
  assign act_we         = fin && (op3.dst == DST_ACT);
  assign act_waddr      = ptr;
  assign act_wdata      = sat[DATA_W-1] ? '0 : sat;
  assign res_vld        = fin && (op3.dst == DST_RES);
  assign res.prediction = sat;
  assign res.saturated  = flag || clip;

endmodule

// File: rtl/mlp2r_seq.sv
module mlp2r_seq
  import mlp2r_pkg::*;
#(
  parameter int H1 = 16,
  parameter int H2 = 16
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        start,
  input  logic                                        mac_busy,
  input  logic                                        out_full,
  output logic                                        idle,
  output mac_op_t                                     op,
  output logic [$clog2(2*H1+H1*H2+2*H2+1)-1:0]        w_raddr,
  output logic [$clog2(H1+H2)-1:0]                    a_raddr
);

  localparam int OFS_B1 = H1;
  localparam int OFS_W2 = 2 * H1;
  localparam int OFS_B2 = OFS_W2 + H1 * H2;
  localparam int OFS_W3 = OFS_B2 + H2;
  localparam int OFS_B3 = OFS_W3 + H2;
  localparam int DEPTH  = OFS_B3 + 1;
  localparam int WA     = $clog2(DEPTH);
  localparam int AA     = $clog2(H1 + H2);
  localparam int MAXH   = (H1 > H2) ? H1 : H2;
  localparam int CW     = $clog2(MAXH + 1);

  seq_state_t    state, state_next;
  phase_t        phase, phase_next;
  logic [CW-1:0] nrn, nrn_next;
  logic [CW-1:0] trm, trm_next;
  logic [WA-1:0] wptr, wptr_next;
  logic [CW-1:0] nterms, nneur, trm_m1;

  always_comb begin
    nterms = CW'(1);
    nneur  = CW'(1);
    case (phase)
      PH_L1: begin
        nneur = CW'(H1);
      end
      PH_L2: begin
        nterms = CW'(H1);
        nneur  = CW'(H2);
      end
      PH_OUT: begin
        nterms = CW'(H2);
      end
      default: begin
      end
    endcase
  end

  assign trm_m1 = trm - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      phase <= PH_NORM;
      nrn   <= '0;
      trm   <= '0;
      wptr  <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      nrn   <= nrn_next;
      trm   <= trm_next;
      wptr  <= wptr_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    nrn_next   = nrn;
    trm_next   = trm;
    wptr_next  = wptr;
    unique case (state)
      SEQ_IDLE: begin
        if (start) begin
          state_next = SEQ_RUN;
          phase_next = PH_NORM;
          nrn_next   = '0;
          trm_next   = '0;
        end
      end
      SEQ_RUN: begin
        if (phase == PH_L2 && trm != '0) begin
          wptr_next = wptr + 1'b1;
        end
        if (trm == nterms) begin
          trm_next = '0;
          if (nrn == nneur - 1'b1) begin
            nrn_next   = '0;
            state_next = SEQ_DRAIN;
          end else begin
            nrn_next = nrn + 1'b1;
          end
        end else begin
          trm_next = trm + 1'b1;
        end
      end
      SEQ_DRAIN: begin
        // next layer reads what this one wrote, so the pipe empties first
        if (!mac_busy) begin
          unique case (phase)
            PH_NORM: begin
              phase_next = PH_L1;
              state_next = SEQ_RUN;
            end
            PH_L1: begin
              phase_next = PH_L2;
              wptr_next  = WA'(OFS_W2);
              state_next = SEQ_RUN;
            end
            PH_L2: begin
              phase_next = PH_OUT;
              state_next = SEQ_RUN;
            end
            PH_OUT: begin
              // result lands in the output register, so it must be free
              if (!out_full) begin
                phase_next = PH_DEN;
                state_next = SEQ_RUN;
              end
            end
            PH_DEN: begin
              state_next = SEQ_IDLE;
            end
            default: begin
              state_next = SEQ_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_next = SEQ_IDLE;
      end
    endcase
  end

  always_comb begin
    op.vld  = (state == SEQ_RUN);
    op.bias = (trm == '0);
    op.last = (trm == nterms);
    op.src  = SRC_NORM;
    op.dst  = DST_X;
    w_raddr = '0;
    a_raddr = '0;
    unique case (phase)
      PH_NORM: begin
        op.src = SRC_NORM;
        op.dst = DST_X;
      end
      PH_L1: begin
        op.src  = SRC_L1;
        op.dst  = DST_ACT;
        w_raddr = op.bias ? WA'(OFS_B1) + WA'(nrn) : WA'(nrn);
      end
      PH_L2: begin
        op.src  = SRC_ACT;
        op.dst  = DST_ACT;
        w_raddr = op.bias ? WA'(OFS_B2) + WA'(nrn) : wptr;
        a_raddr = AA'(trm_m1);
      end
      PH_OUT: begin
        op.src  = SRC_ACT;
        op.dst  = DST_Y;
        w_raddr = op.bias ? WA'(OFS_B3) : WA'(OFS_W3) + WA'(trm_m1);
        a_raddr = AA'(H1) + AA'(trm_m1);
      end
      PH_DEN: begin
        op.src = SRC_DEN;
        op.dst = DST_RES;
      end
      default: begin
      end
    endcase
  end

  assign idle = (state == SEQ_IDLE);

endmodule

// File: rtl/mlp_two_hidden_relu_regressor.sv
// a weight write is taken while idle and gives no result
// a predict runs on one shared 33x32 multiply-accumulate doing one term a cycle,
// with a pipe drain per layer and a wait for the output register to be free
// after a predict the next item is taken once the sequencer is back to idle,
// while the result may still wait
// rst resets control and config registers; weight store contents are kept and unknown until written
module mlp_two_hidden_relu_regressor
  import mlp2r_pkg::*;
#(
  parameter int HIDDEN_ONE = 16,
  parameter int HIDDEN_TWO = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  localparam int H1    = HIDDEN_ONE;
  localparam int H2    = HIDDEN_TWO;
  localparam int DEPTH = 2 * H1 + H1 * H2 + 2 * H2 + 1;
  localparam int WA    = $clog2(DEPTH);
  localparam int AA    = $clog2(H1 + H2);

  logic signed [DATA_W-1:0] input_mean, input_inv_scale, output_scale, output_mean;
  logic signed [DATA_W-1:0] sample;
  logic                     idle, req_xfer, start, w_we, mac_busy;
  mac_op_t                  op;
  logic [WA-1:0]            w_raddr;
  logic [AA-1:0]            a_raddr;
  logic [DATA_W-1:0]        w_rdata, a_rdata;
  logic                     act_we;
  logic [AA-1:0]            act_waddr;
  logic signed [DATA_W-1:0] act_wdata;
  logic                     res_vld;
  rsp_t                     res;

  assign req_stall = !idle;
  assign req_xfer  = req_valid && !req_stall;
  assign start     = req_xfer && (req.func == FUNC_PREDICT);
  assign w_we      = req_xfer && (req.func == FUNC_WRITE) &&
                     (32'(req.weight_index) < 32'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      input_mean      <= '0;
      input_inv_scale <= 32'sd65536;
      output_scale    <= 32'sd65536;
      output_mean     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_INPUT_MEAN:      input_mean      <= cfg_data;
        CFG_INPUT_INV_SCALE: input_inv_scale <= cfg_data;
        CFG_OUTPUT_SCALE:    output_scale    <= cfg_data;
        CFG_OUTPUT_MEAN:     output_mean     <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sample <= req.input_sample;
    end
  end

  // output register parts the result from the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_vld) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      rsp <= res;
    end
  end

  mlp2r_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (WA'(req.weight_index)),
    .wdata (req.weight_value),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  // hidden activations: layer one at the bottom, layer two above it
  mlp2r_ram #(
    .WIDTH (DATA_W),
    .DEPTH (H1 + H2)
  ) u_act_ram (
    .clk   (clk),
    .we    (act_we),
    .waddr (act_waddr),
    .wdata (act_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mlp2r_seq #(
    .H1 (H1),
    .H2 (H2)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .mac_busy (mac_busy),
    .out_full (rsp_valid),
    .idle     (idle),
    .op       (op),
    .w_raddr  (w_raddr),
    .a_raddr  (a_raddr)
  );

  mlp2r_mac #(
    .H1 (H1),
    .H2 (H2)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .op        (op),
    .wdata     (w_rdata),
    .adata     (a_rdata),
    .sample    (sample),
    .in_mean   (input_mean),
    .inv_scale (input_inv_scale),
    .out_scale (output_scale),
    .out_mean  (output_mean),
    .busy      (mac_busy),
    .act_we    (act_we),
    .act_waddr (act_waddr),
    .act_wdata (act_wdata),
    .res_vld   (res_vld),
    .res       (res)
  );

endmodule

// File: verif/tb_mlp_two_hidden_relu_regressor.sv
`timescale 1ns / 100ps

module tb_mlp_two_hidden_relu_regressor;
  import mlp2r_pkg::*;

  localparam int H1 = 16;
  localparam int H2 = 16;
  localparam int OFS_B1 = H1;
  localparam int OFS_W2 = 2 * H1;
  localparam int OFS_B2 = OFS_W2 + H1 * H2;
  localparam int OFS_W3 = OFS_B2 + H2;
  localparam int OFS_B3 = OFS_W3 + H2;
  localparam int STORE_DEPTH = OFS_B3 + 1;

  localparam int CLK_PERIOD = 10;
  localparam int DRAIN_CYCLES = 400;
  localparam int LIMIT_CYCLES = 5000000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int NUM_SETTINGS = 7;
  localparam int WEIGHT_SPAN = 98304;
  localparam int SAMPLE_SPAN = 524288;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  cfg_reg_t cfg_index = CFG_INPUT_MEAN;
  logic [DATA_W-1:0] cfg_data = '0;

  mlp_two_hidden_relu_regressor #(
    .HIDDEN_ONE(H1),
    .HIDDEN_TWO(H2)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // shadow of the weight store and the scaler registers
  logic signed [DATA_W-1:0] weight_shadow [STORE_DEPTH];
  logic signed [DATA_W-1:0] in_mean = 0;
  logic signed [DATA_W-1:0] in_inv_scale = 32'sh0001_0000;
  logic signed [DATA_W-1:0] out_scale = 32'sh0001_0000;
  logic signed [DATA_W-1:0] out_mean = 0;

  rsp_t pending_predictions [$];
  rsp_t want_rsp;

  typedef struct {
    req_t item;
    bit   typed;
    rsp_t want;
  } stim_row_t;

  stim_row_t directed_rows [$];

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned items_sent = 0;
  int unsigned predictions_checked = 0;
  int unsigned settings_used = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  function automatic longint round_q16(longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [DATA_W-1:0] clip32(longint v, inout bit clipped);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return 32'sh8000_0000;
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic rsp_t net_predict(logic signed [DATA_W-1:0] sample);
    logic signed [DATA_W-1:0] act1 [H1];
    logic signed [DATA_W-1:0] act2 [H2];
    logic signed [DATA_W-1:0] xn;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] t;
    longint acc;
    bit clipped;
    rsp_t r;
    clipped = 1'b0;
    acc = longint'(sample) - longint'(in_mean);
    xn = clip32(round_q16(acc * longint'(in_inv_scale)), clipped);
    for (int i = 0; i < H1; i++) begin
      acc = longint'(weight_shadow[OFS_B1 + i])
          + round_q16(longint'(weight_shadow[i]) * longint'(xn));
      t = clip32(acc, clipped);
      act1[i] = (t > 0) ? t : '0;
    end
    for (int i = 0; i < H2; i++) begin
      acc = longint'(weight_shadow[OFS_B2 + i]);
      for (int j = 0; j < H1; j++)
        acc += round_q16(longint'(weight_shadow[OFS_W2 + i * H1 + j]) * longint'(act1[j]));
      t = clip32(acc, clipped);
      act2[i] = (t > 0) ? t : '0;
    end
    acc = longint'(weight_shadow[OFS_B3]);
    for (int j = 0; j < H2; j++)
      acc += round_q16(longint'(weight_shadow[OFS_W3 + j]) * longint'(act2[j]));
    y = clip32(acc, clipped);
    acc = round_q16(longint'(y) * longint'(out_scale)) + longint'(out_mean);
    r.prediction = clip32(acc, clipped);
    r.saturated = clipped;
    return r;
  endfunction

  function automatic req_t mk_req(logic f, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] v,
                                  logic [DATA_W-1:0] s);
    req_t r;
    r.func = f;
    r.weight_index = idx;
    r.weight_value = v;
    r.input_sample = s;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] around_zero(int unsigned span);
    return DATA_W'($urandom_range(2 * span)) - DATA_W'(span);
  endfunction

  function automatic logic [DATA_W-1:0] rand_weight();
    if ($urandom_range(99) < 20)
      return $urandom;
    return around_zero(WEIGHT_SPAN);
  endfunction

  function automatic logic [DATA_W-1:0] rand_sample();
    if ($urandom_range(99) < 30)
      return $urandom;
    return around_zero(SAMPLE_SPAN);
  endfunction

  function automatic void dir_row(logic f, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] v,
                                  logic [DATA_W-1:0] s, bit typed,
                                  logic [DATA_W-1:0] pred, logic sat);
    stim_row_t row;
    row.item = mk_req(f, idx, v, s);
    row.typed = typed;
    row.want.prediction = pred;
    row.want.saturated = sat;
    directed_rows = {directed_rows, row};
  endfunction

  // holds the item until the transfer, then updates the shadow or queues the result
  task automatic send_item(req_t item, bit typed, rsp_t want);
    rsp_t exp_rsp;
    while ($urandom_range(99) < gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    items_sent++;
    if (item.func == FUNC_WRITE) begin
      if (item.weight_index < STORE_DEPTH)
        weight_shadow[item.weight_index] = item.weight_value;
    end else begin
      exp_rsp = typed ? want : net_predict(item.input_sample);
      pending_predictions = {pending_predictions, exp_rsp};
    end
  endtask

  task automatic drain_block();
    req_valid <= 1'b0;
    while (pending_predictions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    case (r)
      CFG_INPUT_MEAN:      in_mean = v;
      CFG_INPUT_INV_SCALE: in_inv_scale = v;
      CFG_OUTPUT_SCALE:    out_scale = v;
      CFG_OUTPUT_MEAN:     out_mean = v;
      default: ;
    endcase
  endtask

  task automatic apply_setting(int p);
    logic [DATA_W-1:0] vals [4];
    case (p)
      0: vals = '{32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000};
      1: vals = '{32'h0001_8000, 32'h0000_8000, 32'h0003_0000, 32'hFFFE_0000};
      2: vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
      3: vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
      4: vals = '{$urandom, $urandom, $urandom, $urandom};
      5: vals = '{around_zero(262144), 32'h0000_0000, 32'hFFFF_0000, $urandom};
      default: vals = '{around_zero(262144), around_zero(131072), around_zero(262144),
                        around_zero(6553600)};
    endcase
    write_reg(CFG_INPUT_MEAN, vals[0]);
    write_reg(CFG_INPUT_INV_SCALE, vals[1]);
    write_reg(CFG_OUTPUT_SCALE, vals[2]);
    write_reg(CFG_OUTPUT_MEAN, vals[3]);
    cfg_we <= 1'b0;
    settings_used++;
    case (p % 4)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 71; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 71; end
      default: begin gap_pct = 30; stall_pct = 30; end
    endcase
  endtask

  task automatic reload_store();
    for (int i = 0; i < STORE_DEPTH; i++)
      send_item(mk_req(FUNC_WRITE, IDX_W'(i), around_zero(WEIGHT_SPAN), $urandom), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_predictions.size());
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_predictions.size() == 0) begin
        $error("result transfer with nothing expected: prediction %0d saturated %0b",
               $signed(rsp.prediction), rsp.saturated);
        fail_count++;
      end else begin
        want_rsp = pending_predictions.pop_front();
        predictions_checked++;
        if (rsp.prediction !== want_rsp.prediction) begin
          $error("prediction: expected %0d, got %0d", $signed(want_rsp.prediction),
                 $signed(rsp.prediction));
          fail_count++;
        end
        if (rsp.saturated !== want_rsp.saturated) begin
          $error("saturated: expected %0b, got %0b", want_rsp.saturated, rsp.saturated);
          fail_count++;
        end
      end
    end
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    int unsigned roll;
    int unsigned n;
    int unsigned base;

    // all weights zero, so the output is just b3 scaled by one
    dir_row(FUNC_PREDICT, 9'd0,   32'h0000_0000, 32'h0000_0000, 1, 32'h0000_0000, 1'b0);
    dir_row(FUNC_WRITE,   9'd320, 32'h7FFF_FFFF, 32'h0000_0000, 0, '0, 1'b0);
    dir_row(FUNC_PREDICT, 9'd0,   32'h0000_0000, 32'h8000_0000, 1, 32'h7FFF_FFFF, 1'b0);
    dir_row(FUNC_WRITE,   9'd320, 32'h8000_0000, 32'h0000_0000, 0, '0, 1'b0);
    dir_row(FUNC_PREDICT, 9'd0,   32'h0000_0000, 32'h7FFF_FFFF, 1, 32'h8000_0000, 1'b0);
    dir_row(FUNC_WRITE,   9'd320, 32'h0001_8000, 32'h0000_0000, 0, '0, 1'b0);
    // hidden neuron 0 clips high, then clips low ahead of the relu
    dir_row(FUNC_WRITE,   9'd0,   32'h7FFF_FFFF, 32'h0000_0000, 0, '0, 1'b0);
    dir_row(FUNC_WRITE,   9'd16,  32'h7FFF_FFFF, 32'h0000_0000, 0, '0, 1'b0);
    dir_row(FUNC_PREDICT, 9'd0,   32'h0000_0000, 32'h7FFF_FFFF, 1, 32'h0001_8000, 1'b1);
    dir_row(FUNC_WRITE,   9'd16,  32'h8000_0000, 32'h0000_0000, 0, '0, 1'b0);
    dir_row(FUNC_PREDICT, 9'd0,   32'h0000_0000, 32'h8000_0000, 1, 32'h0001_8000, 1'b1);
    // writes past the store must not land anywhere
    dir_row(FUNC_WRITE,   9'd321, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, '0, 1'b0);
    dir_row(FUNC_WRITE,   9'd511, 32'hFFFF_FFFF, 32'h0000_0000, 0, '0, 1'b0);
    // a predict carrying the b3 address and a value must not write it
    dir_row(FUNC_PREDICT, 9'd320, 32'h7FFF_FFFF, 32'h0000_0000, 1, 32'h0001_8000, 1'b0);
    dir_row(FUNC_PREDICT, 9'd0,   32'h0000_0000, 32'h0000_0000, 1, 32'h0001_8000, 1'b0);
    dir_row(FUNC_WRITE,   9'd16,  32'h0002_0000, 32'h0000_0000, 0, '0, 1'b0);
    dir_row(FUNC_WRITE,   9'd0,   32'h0000_8000, 32'h0000_0000, 0, '0, 1'b0);
    dir_row(FUNC_WRITE,   9'd32,  32'h0001_0000, 32'hDEAD_BEEF, 0, '0, 1'b0);
    dir_row(FUNC_WRITE,   9'd304, 32'hFFFF_0000, 32'h0000_0000, 0, '0, 1'b0);
    dir_row(FUNC_PREDICT, 9'd0,   32'h0000_0000, 32'h0004_0000, 0, '0, 1'b0);
    dir_row(FUNC_PREDICT, 9'd0,   32'h0000_0000, 32'h8000_0000, 0, '0, 1'b0);
    // output neuron sum overflows
    dir_row(FUNC_WRITE,   9'd304, 32'h7FFF_FFFF, 32'h0000_0000, 0, '0, 1'b0);
    dir_row(FUNC_WRITE,   9'd320, 32'h7FFF_FFFF, 32'h0000_0000, 0, '0, 1'b0);
    dir_row(FUNC_PREDICT, 9'd0,   32'h0000_0000, 32'h0004_0000, 0, '0, 1'b0);
    dir_row(FUNC_PREDICT, 9'd0,   32'h0000_0000, 32'hFFFC_0000, 0, '0, 1'b0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // every entry is written before any predict reads it
    for (int i = 0; i < STORE_DEPTH; i++)
      send_item(mk_req(FUNC_WRITE, IDX_W'(i), '0, $urandom), 1'b0, '0);
    foreach (directed_rows[k])
      send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);
    drain_block();
    reload_store();

    base = items_sent;
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      drain_block();
      apply_setting(p);
      while (items_sent - base < (p + 1) * RANDOM_ITEMS / NUM_SETTINGS) begin
        roll = $urandom_range(99);
        if (roll == 0) begin
          reload_store();
        end else if (roll < 31) begin
          n = $urandom_range(1, 6);
          repeat (n) begin
            if ($urandom_range(9) == 0)
              send_item(mk_req(FUNC_WRITE, IDX_W'($urandom_range(STORE_DEPTH, 511)),
                               $urandom, $urandom), 1'b0, '0);
            else
              send_item(mk_req(FUNC_WRITE, IDX_W'($urandom_range(STORE_DEPTH - 1)),
                               rand_weight(), $urandom), 1'b0, '0);
          end
        end else begin
          n = $urandom_range(1, 4);
          repeat (n)
            send_item(mk_req(FUNC_PREDICT, IDX_W'($urandom), $urandom, rand_sample()),
                      1'b0, '0);
        end
      end
    end
    drain_block();

    $display("sent %0d items under %0d scaler settings and four idle/stall mixes",
             items_sent, settings_used);
    $display("checked %0d predictions, %0d mismatches", predictions_checked, fail_count);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
